FILE: hdl/vnorm_pkg.sv
// Package for the vector normalizer: widths and default parameters.
package vnorm_pkg;

    localparam int COMP_W_DEF = 16;
    localparam int FRAC_W_DEF = 14;
    localparam int UNIT_W     = 16;

endpackage

FILE: hdl/vnorm_sqrt_cell.sv
// One digit step of the pipelined restoring integer square root.
module vnorm_sqrt_cell
    import vnorm_pkg::*;
#(
    parameter int SW   = 34,
    parameter int RW   = 17,
    parameter int STEP = 0,
    parameter int AW   = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [SW-1:0] in_rem,
    input  logic [RW-1:0] in_root,
    input  logic [AW-1:0] in_ax,
    input  logic [AW-1:0] in_ay,
    input  logic [AW-1:0] in_az,
    input  logic [2:0]    in_neg,
    output logic          out_vld,
    output logic [SW-1:0] out_rem,
    output logic [RW-1:0] out_root,
    output logic [AW-1:0] out_ax,
    output logic [AW-1:0] out_ay,
    output logic [AW-1:0] out_az,
    output logic [2:0]    out_neg
);

    // bit position of the root digit decided in this cell
    localparam int BP = RW - 1 - STEP;

    logic [SW+1:0] trial;
    logic [SW+1:0] rem_ext;
    logic          vld_reg;
    logic [SW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [AW-1:0] ax_reg, ay_reg, az_reg;
    logic [2:0]    neg_reg;

    // trial subtrahend (2*root + 2^bp) * 2^bp with root bits above bp only
    always_comb
    begin
        trial   = ({2'b0, {(SW-RW){1'b0}}, in_root} << (BP + 1))
                  | ({{(SW+1){1'b0}}, 1'b1} << (2 * BP));
        rem_ext = {2'b0, in_rem};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rem_ext >= trial)
        begin
            rem_reg  <= SW'(rem_ext - trial);
            root_reg <= in_root | (RW'(1) << BP);
        end
        else
        begin
            rem_reg  <= in_rem;
            root_reg <= in_root;
        end
        ax_reg  <= in_ax;
        ay_reg  <= in_ay;
        az_reg  <= in_az;
        neg_reg <= in_neg;
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_ax   = ax_reg;
    assign out_ay   = ay_reg;
    assign out_az   = az_reg;
    assign out_neg  = neg_reg;

endmodule

FILE: hdl/vnorm_div_cell.sv
// One quotient bit step of three parallel restoring dividers sharing the magnitude.
module vnorm_div_cell
    import vnorm_pkg::*;
#(
    parameter int RW   = 17,
    parameter int QW   = 31
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [RW-1:0] in_den,
    input  logic [QW-1:0] in_num [3],
    input  logic [RW-1:0] in_rem [3],
    input  logic [2:0]    in_neg,
    output logic          out_vld,
    output logic [RW-1:0] out_den,
    output logic [QW-1:0] out_num [3],
    output logic [RW-1:0] out_rem [3],
    output logic [2:0]    out_neg
);

    logic          vld_reg;
    logic [RW-1:0] den_reg;
    logic [QW-1:0] num_reg [3];
    logic [RW-1:0] rem_reg [3];
    logic [2:0]    neg_reg;
    logic [RW:0]   shl    [3];

    // shift in the next numerator bit, quotient bit replaces it at the bottom
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shl[i] = {in_rem[i], in_num[i][QW-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= in_den;
        neg_reg <= in_neg;
        for (int i = 0; i < 3; i++)
        begin
            if (shl[i] >= {1'b0, in_den})
            begin
                rem_reg[i] <= RW'(shl[i] - {1'b0, in_den});
                num_reg[i] <= {in_num[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= shl[i][RW-1:0];
                num_reg[i] <= {in_num[i][QW-2:0], 1'b0};
            end
        end
    end

    assign out_vld = vld_reg;
    assign out_den = den_reg;
    assign out_num = num_reg;
    assign out_rem = rem_reg;
    assign out_neg = neg_reg;

endmodule

FILE: hdl/vector3_normalizer.sv
// Top level: fully pipelined 3D vector normalizer built from square-root and divider cells.
// Pipeline from start to done: input and sum stages, COMPONENT_WIDTH+1 sqrt cells,
// COMPONENT_WIDTH+FRACTION_BITS divider cells, then the output register.
// Throughput: one vector per cycle, busy stays low.
// Reset clears only the valid bits of the stages and cells; no results are in flight after it.
// The receiver cannot stall: done is a one-cycle strobe.
module vector3_normalizer
    import vnorm_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_W_DEF,
    parameter int FRACTION_BITS   = FRAC_W_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COMPONENT_WIDTH-1:0] vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0] vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0] vec_z,
    output logic                              done,
    output logic signed [UNIT_W-1:0]          unit_x,
    output logic signed [UNIT_W-1:0]          unit_y,
    output logic signed [UNIT_W-1:0]          unit_z,
    output logic                              zero_length
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int AW = CW;                 // magnitude incl. 2^(CW-1)
    localparam int SW = 2 * AW + 2;         // sum of three squares
    localparam int RW = (SW + 1) / 2;       // root width
    localparam int QW = AW + FRACTION_BITS; // quotient bits

    // stage 1: split sign and magnitude, square
    logic          s1_vld_reg;
    logic [AW-1:0] s1_a_reg [3];
    logic [2:0]    s1_neg_reg;
    logic [2*AW-1:0] s1_sq_reg [3];
    logic [AW-1:0] abs_in [3];
    logic [2:0]    neg_in;
    logic [CW-1:0] raw_in [3];

    always_comb
    begin
        raw_in[0] = vec_x;
        raw_in[1] = vec_y;
        raw_in[2] = vec_z;
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = raw_in[i][CW-1];
            abs_in[i] = neg_in[i] ? AW'(-raw_in[i]) : raw_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg <= neg_in;
        for (int i = 0; i < 3; i++)
        begin
            s1_a_reg[i]  <= abs_in[i];
            s1_sq_reg[i] <= abs_in[i] * abs_in[i];
        end
    end

    // stage 2: sum of squares
    logic          s2_vld_reg;
    logic [SW-1:0] s2_sum_reg;
    logic [AW-1:0] s2_a_reg [3];
    logic [2:0]    s2_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg <= SW'(s1_sq_reg[0]) + SW'(s1_sq_reg[1]) + SW'(s1_sq_reg[2]);
        s2_a_reg   <= s1_a_reg;
        s2_neg_reg <= s1_neg_reg;
    end

    // square root chain, one cell per root bit
    logic          sq_vld  [RW+1];
    logic [SW-1:0] sq_rem  [RW+1];
    logic [RW-1:0] sq_root [RW+1];
    logic [AW-1:0] sq_ax [RW+1], sq_ay [RW+1], sq_az [RW+1];
    logic [2:0]    sq_neg  [RW+1];

    assign sq_vld[0]  = s2_vld_reg;
    assign sq_rem[0]  = s2_sum_reg;
    assign sq_root[0] = '0;
    assign sq_ax[0]   = s2_a_reg[0];
    assign sq_ay[0]   = s2_a_reg[1];
    assign sq_az[0]   = s2_a_reg[2];
    assign sq_neg[0]  = s2_neg_reg;

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        vnorm_sqrt_cell #(.SW(SW), .RW(RW), .STEP(g), .AW(AW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_vld(sq_vld[g]), .in_rem(sq_rem[g]), .in_root(sq_root[g]),
            .in_ax(sq_ax[g]), .in_ay(sq_ay[g]), .in_az(sq_az[g]), .in_neg(sq_neg[g]),
            .out_vld(sq_vld[g+1]), .out_rem(sq_rem[g+1]), .out_root(sq_root[g+1]),
            .out_ax(sq_ax[g+1]), .out_ay(sq_ay[g+1]), .out_az(sq_az[g+1]),
            .out_neg(sq_neg[g+1])
        );
    end

    // divider chain, one cell per quotient bit
    logic          dv_vld [QW+1];
    logic [RW-1:0] dv_den [QW+1];
    logic [QW-1:0] dv_num [QW+1][3];
    logic [RW-1:0] dv_rem [QW+1][3];
    logic [2:0]    dv_neg [QW+1];

    assign dv_vld[0]    = sq_vld[RW];
    assign dv_den[0]    = sq_root[RW];
    assign dv_num[0][0] = {sq_ax[RW], {FRACTION_BITS{1'b0}}};
    assign dv_num[0][1] = {sq_ay[RW], {FRACTION_BITS{1'b0}}};
    assign dv_num[0][2] = {sq_az[RW], {FRACTION_BITS{1'b0}}};
    assign dv_rem[0][0] = '0;
    assign dv_rem[0][1] = '0;
    assign dv_rem[0][2] = '0;
    assign dv_neg[0]    = sq_neg[RW];

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        vnorm_div_cell #(.RW(RW), .QW(QW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_vld(dv_vld[g]), .in_den(dv_den[g]), .in_num(dv_num[g]),
            .in_rem(dv_rem[g]), .in_neg(dv_neg[g]),
            .out_vld(dv_vld[g+1]), .out_den(dv_den[g+1]), .out_num(dv_num[g+1]),
            .out_rem(dv_rem[g+1]), .out_neg(dv_neg[g+1])
        );
    end

    // output stage: saturate, apply sign, flag zero vector
    localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (UNIT_W - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_MAX = QW'(64'd1 << (UNIT_W - 1));

    logic              out_vld_reg;
    logic [UNIT_W-1:0] unit_reg [3];
    logic              zero_reg;
    logic [QW-1:0]     q_sat [3];
    logic              is_zero;

    always_comb
    begin
        is_zero = (dv_den[QW] == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (dv_neg[QW][i])
            begin
                q_sat[i] = (dv_num[QW][i] > NEG_MAX) ? NEG_MAX : dv_num[QW][i];
                q_sat[i] = QW'(-q_sat[i]);
            end
            else
            begin
                q_sat[i] = (dv_num[QW][i] > POS_MAX) ? POS_MAX : dv_num[QW][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= dv_vld[QW];
        end
    end

    // sign-extend or truncate the quotient to the output width
    always_ff @(posedge clk)
    begin
        zero_reg <= is_zero;
        for (int i = 0; i < 3; i++)
        begin
            unit_reg[i] <= is_zero ? '0 : UNIT_W'(signed'(q_sat[i]));
        end
    end

    assign busy        = 1'b0;
    assign done        = out_vld_reg;
    assign unit_x      = unit_reg[0];
    assign unit_y      = unit_reg[1];
    assign unit_z      = unit_reg[2];
    assign zero_length = zero_reg;

    // a zero flag must come with all-zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
        else $error("zero vector gave nonzero output");

    // no x component magnitude beyond one when the format allows it
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done && FRACTION_BITS <= UNIT_W - 2 |->
        (unit_x <= (1 <<< FRACTION_BITS)) && (unit_x >= -(1 <<< FRACTION_BITS)))
        else $error("unit_x out of range");

    // the root leaving the sqrt chain is never smaller than any component magnitude
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[RW] |-> sq_root[RW] >= RW'(sq_ax[RW]) && sq_root[RW] >= RW'(sq_ay[RW])
        && sq_root[RW] >= RW'(sq_az[RW]))
        else $error("root below a component");

endmodule
